>>> design/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel generator package
// Widths, register indexes, reset values and shared types of the line engine.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 32;

   localparam int ERR_BITS    = COORD_BITS + 1;
   localparam int DIM_BITS    = 12;
   localparam int PITCH_BITS  = 14;
   localparam int BPP_BITS    = 3;
   localparam int OFFSET_BITS = 24;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 14;

   localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int SUM_BITS = (COORD_BITS + PITCH_BITS > OFFSET_BITS) ?
                             (COORD_BITS + PITCH_BITS) : OFFSET_BITS;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_PITCH       = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 2'd3;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 12'd640;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 12'd480;
   localparam logic [PITCH_BITS-1:0] PITCH_RESET  = 14'd2560;
   localparam logic [BPP_BITS-1:0]   BPP_RESET    = 3'd4;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]        color;
      logic                         last;
   } pixel_type;

endpackage

>>> design/line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// Line pixel generator unit
// Bresenham line stepper that turns start and advance commands into pixels
// with clip flag and frame buffer byte offset.
// ----------------------------------------------------------------------------
// A pixel passes through the pixel register and then the response register.
// One request per cycle while req_ready is high; a start, or an advance while
// busy, updates the line state on accept. The offset multiply sits in the
// second stage, after the pixel register. Reset clears the busy flag and stage
// valids; screen registers load 640 by 480, a 2560 byte pitch, 4 bytes/pixel.
module line_pixel_generator_unit
   import lpg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   input  logic [COLOR_BITS-1:0]        req_color,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_inside_res,
   output logic [OFFSET_BITS-1:0]       rsp_byte_offset,
   output logic [COLOR_BITS-1:0]        rsp_pixel_value,
   output logic                         rsp_last,

   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [PITCH_BITS-1:0] pitch_ff, pitch_in;
   logic [BPP_BITS-1:0]   bpp_ff, bpp_in;

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] tgt_x_ff, tgt_x_in;
   logic [COORD_BITS-1:0] tgt_y_ff, tgt_y_in;
   logic [COORD_BITS-1:0] major_ff, major_in;
   logic [COORD_BITS-1:0] minor_ff, minor_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic [1:0]            step_x_ff, step_x_in;
   logic [1:0]            step_y_ff, step_y_in;
   logic                  x_major_ff, x_major_in;
   logic                  busy_ff, busy_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   pixel_type             pix_ff, pix_in;
   logic                  pix_valid_ff, pix_valid_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                         rsp_inside_ff, rsp_inside_in;
   logic [OFFSET_BITS-1:0]       rsp_offset_ff, rsp_offset_in;
   logic [COLOR_BITS-1:0]        rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  is_start;
   logic                  pix_go;
   logic                  out_free;
   logic                  pix_move;

   logic [COORD_BITS:0]   dx, dy, neg_dx, neg_dy;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  st_x_major;
   logic [COORD_BITS-1:0] st_major;

   logic [ERR_BITS-1:0]   err_sum;
   logic                  minor_step;
   logic [COORD_BITS-1:0] x_inc, y_inc;
   logic                  at_end_next;

   logic                  on_screen;
   logic [CMP_BITS-1:0]   x_cmp, y_cmp;
   logic [SUM_BITS-1:0]   y_term, x_term, offset_sum;

   // Request and response handshakes
   assign accept    = req_valid && req_ready;
   assign is_start  = (req_cmd == CMD_START);
   assign pix_go    = accept && (is_start || busy_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pix_move  = pix_valid_ff && out_free;
   assign req_ready = !pix_valid_ff || out_free;

   // Configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;
      bpp_in    = bpp_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:    width_in  = csr_wdata[DIM_BITS-1:0];
            REG_SCREEN_HEIGHT:   height_in = csr_wdata[DIM_BITS-1:0];
            REG_ROW_PITCH:       pitch_in  = csr_wdata[PITCH_BITS-1:0];
            REG_BYTES_PER_PIXEL: bpp_in    = csr_wdata[BPP_BITS-1:0];
            default:             width_in  = width_ff;
         endcase
      end
   end

   // Line setup
   always_comb begin
      dx     = {req_x_end[COORD_BITS-1], req_x_end} - {req_x_start[COORD_BITS-1], req_x_start};
      dy     = {req_y_end[COORD_BITS-1], req_y_end} - {req_y_start[COORD_BITS-1], req_y_start};
      neg_dx = -dx;
      neg_dy = -dy;
      adx    = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady    = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      st_x_major = (ady < adx);
      st_major   = st_x_major ? adx : ady;
   end

   // Bresenham step
   always_comb begin
      err_sum    = err_ff + {1'b0, minor_ff};
      minor_step = (err_sum > {1'b0, major_ff});
      x_inc      = {{(COORD_BITS-2){step_x_ff[1]}}, step_x_ff};
      y_inc      = {{(COORD_BITS-2){step_y_ff[1]}}, step_y_ff};
   end

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      err_in     = err_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      x_major_in = x_major_ff;
      color_in   = color_ff;
      if (is_start) begin
         cur_x_in   = req_x_start;
         cur_y_in   = req_y_start;
         tgt_x_in   = req_x_end;
         tgt_y_in   = req_y_end;
         x_major_in = st_x_major;
         major_in   = st_major;
         minor_in   = st_x_major ? ady : adx;
         err_in     = {2'b00, st_major[COORD_BITS-1:1]};
         step_x_in  = (dx == '0) ? 2'b00 : (dx[COORD_BITS] ? 2'b11 : 2'b01);
         step_y_in  = (dy == '0) ? 2'b00 : (dy[COORD_BITS] ? 2'b11 : 2'b01);
         color_in   = req_color;
      end else begin
         err_in = minor_step ? (err_sum - {1'b0, major_ff}) : err_sum;
         if (x_major_ff || minor_step) begin
            cur_x_in = cur_x_ff + x_inc;
         end
         if (!x_major_ff || minor_step) begin
            cur_y_in = cur_y_ff + y_inc;
         end
      end
      at_end_next = x_major_in ? (cur_x_in == tgt_x_in) : (cur_y_in == tgt_y_in);
      busy_in     = !at_end_next;
   end

   // Pixel register
   always_comb begin
      pix_in.x     = cur_x_in;
      pix_in.y     = cur_y_in;
      pix_in.color = color_in;
      pix_in.last  = at_end_next;
      if (pix_go) begin
         pix_valid_in = 1'b1;
      end else if (pix_move) begin
         pix_valid_in = 1'b0;
      end else begin
         pix_valid_in = pix_valid_ff;
      end
   end

   // Clip test and byte offset
   always_comb begin
      x_cmp     = CMP_BITS'(pix_ff.x[COORD_BITS-2:0]);
      y_cmp     = CMP_BITS'(pix_ff.y[COORD_BITS-2:0]);
      on_screen = !pix_ff.x[COORD_BITS-1] && !pix_ff.y[COORD_BITS-1] &&
                  (x_cmp < CMP_BITS'(width_ff)) && (y_cmp < CMP_BITS'(height_ff));
      y_term     = SUM_BITS'(pix_ff.y[COORD_BITS-2:0]) * SUM_BITS'(pitch_ff);
      x_term     = SUM_BITS'(pix_ff.x[COORD_BITS-2:0]) * SUM_BITS'(bpp_ff);
      offset_sum = y_term + x_term;

      rsp_x_in      = pix_ff.x;
      rsp_y_in      = pix_ff.y;
      rsp_inside_in = on_screen;
      rsp_offset_in = on_screen ? offset_sum[OFFSET_BITS-1:0] : '0;
      rsp_value_in  = pix_ff.color;
      rsp_last_in   = pix_ff.last;
      if (pix_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         pitch_ff     <= PITCH_RESET;
         bpp_ff       <= BPP_RESET;
         busy_ff      <= 1'b0;
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         pitch_ff     <= pitch_in;
         bpp_ff       <= bpp_in;
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pix_go) begin
            busy_ff <= busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_go) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         tgt_x_ff   <= tgt_x_in;
         tgt_y_ff   <= tgt_y_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         err_ff     <= err_in;
         step_x_ff  <= step_x_in;
         step_y_ff  <= step_y_in;
         x_major_ff <= x_major_in;
         color_ff   <= color_in;
         pix_ff     <= pix_in;
      end
      if (pix_move) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_inside_ff <= rsp_inside_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_byte_offset = rsp_offset_ff;
   assign rsp_pixel_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> design/lpg_checker.sv
// ----------------------------------------------------------------------------
// Line pixel generator checker
// Port level assertions for the line pixel generator unit.
// ----------------------------------------------------------------------------
module lpg_checker
   import lpg_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_inside_res,
   input logic [OFFSET_BITS-1:0]       rsp_byte_offset,
   input logic                         rsp_last
);

   // No pixel is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A stalled pixel keeps its transfer pending with the same content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) &&
      $stable(rsp_pixel_y) && $stable(rsp_last) && $stable(rsp_byte_offset))
      else $error("stalled pixel changed");

   // Clipped pixels carry a zero offset.
   a_clip_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_byte_offset == '0)
      else $error("nonzero offset on clipped pixel");

   // Visible pixels never have negative coordinates.
   a_inside_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |->
      !rsp_pixel_x[COORD_BITS-1] && !rsp_pixel_y[COORD_BITS-1])
      else $error("visible pixel with negative coordinate");

   // With the output register empty, the unit always takes requests.
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_inside_res  (rsp_inside_res),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_last        (rsp_last)
);
